// ----- rtl/core/dirb_pkg.sv -----
// Shared address map, access codes and decode record for the DMA/interrupt register block.
`timescale 1ns / 1ps

package dirb_pkg;

  // Access commands and sizes
  localparam logic       CMD_READ   = 1'b0;
  localparam logic       CMD_WRITE  = 1'b1;
  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_HALF  = 2'd1;
  localparam logic [1:0] SIZE_WORD  = 2'd2;

  // Address map
  localparam logic [31:0] ADDR_IGNORE = 32'hFFFE_0000;
  localparam logic [31:0] A_ISTAT     = 32'h1F80_1070;
  localparam logic [31:0] A_IMASK     = 32'h1F80_1074;
  localparam logic [31:0] A_ICTRL     = 32'h1F80_1078;
  localparam logic [31:0] A_DICR      = 32'h1F80_10F4;
  localparam logic [31:0] A_DPCR2     = 32'h1F80_1570;
  localparam logic [31:0] A_DICR2     = 32'h1F80_1574;
  localparam logic [31:0] A_DMACEN    = 32'h1F80_1578;
  localparam logic [31:0] A_DMACINTEN = 32'h1F80_157C;
  localparam logic [31:0] A_CH_LO     = 32'h1F80_1080;
  localparam logic [31:0] A_CH_LO_END = 32'h1F80_10F0;
  localparam logic [31:0] A_CH_HI     = 32'h1F80_1500;

  // Channel control register slot and its start bit
  localparam logic [1:0] CH_CTRL_SLOT  = 2'd2;
  localparam int         START_BIT_POS = 24;
  localparam logic [3:0] CH_DONE_A     = 4'd4;
  localparam logic [3:0] CH_DONE_B     = 4'd7;

  // Register kinds hit by an access
  localparam logic [3:0] KIND_NONE      = 4'd0;
  localparam logic [3:0] KIND_ISTAT     = 4'd1;
  localparam logic [3:0] KIND_IMASK     = 4'd2;
  localparam logic [3:0] KIND_ICTRL     = 4'd3;
  localparam logic [3:0] KIND_DICR      = 4'd4;
  localparam logic [3:0] KIND_DPCR2     = 4'd5;
  localparam logic [3:0] KIND_DICR2     = 4'd6;
  localparam logic [3:0] KIND_DMACEN    = 4'd7;
  localparam logic [3:0] KIND_DMACINTEN = 4'd8;
  localparam logic [3:0] KIND_CHAN      = 4'd9;

  // Decoded access
  typedef struct packed {
    logic [3:0] kind;
    logic       is_write;
    logic [1:0] size;
    logic [1:0] byte_lane;
    logic       ch_ctrl;
    logic       ch_done_a;
    logic       ch_done_b;
  } access_info_t;

endpackage

// ----- rtl/core/dirb_decode.sv -----
// Address decode: named register or channel memory index for one bus access.
`timescale 1ns / 1ps

module dirb_decode #(
  parameter int CHANNEL_COUNT = 13
) (
  input  logic                                   command,
  input  logic [31:0]                            address,
  input  logic [1:0]                             access_size,
  output dirb_pkg::access_info_t                 info,
  output logic [$clog2(CHANNEL_COUNT*4)-1:0]     chan_idx
);

  localparam int          IDX_W     = $clog2(CHANNEL_COUNT * 4);
  localparam logic [31:0] CH_HI_END = dirb_pkg::A_CH_HI + 32'((CHANNEL_COUNT - 7) * 16);

  logic        ignore;
  logic        sub_read;
  logic [31:0] la;
  logic        in_lo;
  logic        in_hi;
  logic [3:0]  ch;
  logic        ch_ok;

  // Lookup address: upper bits dropped, sub-word reads aligned to the word
  assign ignore   = address >= dirb_pkg::ADDR_IGNORE;
  assign sub_read = (command == dirb_pkg::CMD_READ) && (access_size < dirb_pkg::SIZE_WORD);
  assign la       = {3'b000, address[28:2], sub_read ? 2'b00 : address[1:0]};

  // Channel windows
  assign in_lo = (la >= dirb_pkg::A_CH_LO) && (la < dirb_pkg::A_CH_LO_END);
  assign in_hi = (la >= dirb_pkg::A_CH_HI) && (la < CH_HI_END);
  assign ch    = in_lo ? (la[7:4] - 4'd8) : (la[7:4] + 4'd7);
  assign ch_ok = (in_lo || in_hi) && ({1'b0, ch} < 5'(CHANNEL_COUNT));

  assign chan_idx = IDX_W'({ch, la[3:2]});

  // Named registers take precedence over channel space
  always_comb begin
    info           = '0;
    info.is_write  = command;
    info.size      = access_size;
    info.byte_lane = address[1:0];
    info.ch_ctrl   = la[3:2] == dirb_pkg::CH_CTRL_SLOT;
    info.ch_done_a = ch == dirb_pkg::CH_DONE_A;
    info.ch_done_b = ch == dirb_pkg::CH_DONE_B;
    case (la)
      dirb_pkg::A_ISTAT:     info.kind = dirb_pkg::KIND_ISTAT;
      dirb_pkg::A_IMASK:     info.kind = dirb_pkg::KIND_IMASK;
      dirb_pkg::A_ICTRL:     info.kind = dirb_pkg::KIND_ICTRL;
      dirb_pkg::A_DICR:      info.kind = dirb_pkg::KIND_DICR;
      dirb_pkg::A_DPCR2:     info.kind = dirb_pkg::KIND_DPCR2;
      dirb_pkg::A_DICR2:     info.kind = dirb_pkg::KIND_DICR2;
      dirb_pkg::A_DMACEN:    info.kind = dirb_pkg::KIND_DMACEN;
      dirb_pkg::A_DMACINTEN: info.kind = dirb_pkg::KIND_DMACINTEN;
      default:               info.kind = ch_ok ? dirb_pkg::KIND_CHAN : dirb_pkg::KIND_NONE;
    endcase
    if (ignore) begin
      info.kind = dirb_pkg::KIND_NONE;
    end
  end

endmodule

// ----- rtl/core/dma_interrupt_register_block.sv -----
// Top level: DMA and interrupt control register block with channel register memory.
`timescale 1ns / 1ps

// Each bus access is handled in an accept step and an execute step: in the accept cycle the address is decoded
// and the channel register memory is read (registered synchronous read); in the
// execute state the block reads, modifies and writes back the state and loads the
// result register. The block takes no new item until the execute state is done,
// and the execute state waits while a previous result is still
// held on the output. A new item can be accepted while a result waits. Channel
// registers live in a CHANNEL_COUNT*4-word memory with one valid bit per word,
// cleared at reset, so no clearing pass is needed. Writing the control word of
// channel 4 or 7 completes it at once; starting any other channel flags start_fault.
module dma_interrupt_register_block #(
  parameter int CHANNEL_COUNT = 13
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] command, [32:1] address, [64:33] write_data, [66:65] access_size, [71:67] zero
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] read_data, [32] decoded, [33] start_fault, [39:34] zero
  output logic [39:0] m_tdata
);

  localparam int DEPTH = CHANNEL_COUNT * 4;
  localparam int IDX_W = $clog2(DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic accept;
  logic commit;

  // Decode of the incoming item
  dirb_pkg::access_info_t info_in;
  logic [IDX_W-1:0]       idx_in;

  dirb_decode #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_decode (
    .command     (s_tdata[0]),
    .address     (s_tdata[32:1]),
    .access_size (s_tdata[66:65]),
    .info        (info_in),
    .chan_idx    (idx_in)
  );

  // Item held for the execute cycle
  dirb_pkg::access_info_t info_q;
  logic [IDX_W-1:0]       idx_q;
  logic [31:0]            wdata_q;

  // Channel register memory
  logic [31:0]      chan_mem [DEPTH];
  logic [DEPTH-1:0] chan_valid;
  logic [31:0]      mem_q;
  logic             mem_valid_q;
  logic             mem_we;
  logic [31:0]      mem_wdata;

  // Named registers
  logic [31:0] irq_status, irq_status_next;
  logic [31:0] irq_mask, irq_mask_next;
  logic        irq_ctrl_bit, irq_ctrl_bit_next;
  logic [15:0] dicr_low_ctrl, dicr_low_ctrl_next;
  logic [6:0]  dicr_enables, dicr_enables_next;
  logic        dicr_master_enable, dicr_master_enable_next;
  logic [6:0]  dicr_flags, dicr_flags_next;
  logic        dicr_master_flag, dicr_master_flag_next;
  logic [15:0] dicr2_tag_bits, dicr2_tag_bits_next;
  logic [6:0]  dicr2_enables, dicr2_enables_next;
  logic [6:0]  dicr2_flags, dicr2_flags_next;
  logic [31:0] priority_word, priority_word_next;
  logic [31:0] dma_enable_word, dma_enable_word_next;
  logic [31:0] dma_int_enable_word, dma_int_enable_word_next;

  // Result
  logic [31:0] rd_word;
  logic [31:0] rd_result;
  logic        hit;
  logic        fault;
  logic [31:0] read_data_q;
  logic        decoded_q;
  logic        start_fault_q;

  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign commit   = (state == ST_EXEC) && (!m_tvalid || m_tready);

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        state <= ST_EXEC;
      end else if (commit) begin
        state <= ST_IDLE;
      end
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Capture of the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      info_q  <= info_in;
      idx_q   <= idx_in;
      wdata_q <= s_tdata[64:33];
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q       <= chan_mem[idx_in];
      mem_valid_q <= chan_valid[idx_in];
    end
  end

  // Memory write port
  always_ff @(posedge clk) begin
    if (commit && mem_we) begin
      chan_mem[idx_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_valid <= '0;
    end else if (commit && mem_we) begin
      chan_valid[idx_q] <= 1'b1;
    end
  end

  // Read-modify-write of the state for the held item
  always_comb begin
    irq_status_next          = irq_status;
    irq_mask_next            = irq_mask;
    irq_ctrl_bit_next        = irq_ctrl_bit;
    dicr_low_ctrl_next       = dicr_low_ctrl;
    dicr_enables_next        = dicr_enables;
    dicr_master_enable_next  = dicr_master_enable;
    dicr_flags_next          = dicr_flags;
    dicr_master_flag_next    = dicr_master_flag;
    dicr2_tag_bits_next      = dicr2_tag_bits;
    dicr2_enables_next       = dicr2_enables;
    dicr2_flags_next         = dicr2_flags;
    priority_word_next       = priority_word;
    dma_enable_word_next     = dma_enable_word;
    dma_int_enable_word_next = dma_int_enable_word;
    rd_word                  = '0;
    fault                    = 1'b0;
    mem_we                   = 1'b0;
    mem_wdata                = wdata_q;
    hit                      = info_q.kind != dirb_pkg::KIND_NONE;

    if (info_q.is_write == dirb_pkg::CMD_WRITE) begin
      case (info_q.kind)
        dirb_pkg::KIND_ISTAT:     irq_status_next = irq_status & wdata_q;
        dirb_pkg::KIND_IMASK:     irq_mask_next = wdata_q;
        dirb_pkg::KIND_ICTRL:     irq_ctrl_bit_next = wdata_q[0];
        dirb_pkg::KIND_DICR: begin
          dicr_low_ctrl_next      = wdata_q[15:0];
          dicr_enables_next       = wdata_q[22:16];
          dicr_master_enable_next = wdata_q[23];
          dicr_flags_next         = dicr_flags & ~wdata_q[30:24];
          dicr_master_flag_next   = (dicr_flags_next != '0) || (dicr2_flags != '0);
        end
        dirb_pkg::KIND_DICR2: begin
          dicr2_tag_bits_next   = wdata_q[15:0];
          dicr2_enables_next    = wdata_q[22:16];
          dicr2_flags_next      = dicr2_flags & ~wdata_q[30:24];
          dicr_master_flag_next = (dicr_flags != '0) || (dicr2_flags_next != '0);
        end
        dirb_pkg::KIND_DPCR2:     priority_word_next = wdata_q;
        dirb_pkg::KIND_DMACEN:    dma_enable_word_next = wdata_q;
        dirb_pkg::KIND_DMACINTEN: dma_int_enable_word_next = wdata_q;
        dirb_pkg::KIND_CHAN: begin
          mem_we = 1'b1;
          if (info_q.ch_ctrl && info_q.ch_done_a) begin
            // channel 4 completes at once
            mem_wdata[dirb_pkg::START_BIT_POS] = 1'b0;
            if (dicr_master_enable && dicr_enables[4]) begin
              dicr_flags_next[4] = 1'b1;
            end
            dicr_master_flag_next = dicr_master_enable &&
                                    ((dicr_flags_next != '0) || (dicr2_flags != '0));
            if (dicr_master_flag_next) begin
              irq_status_next[3] = 1'b1;
            end
          end else if (info_q.ch_ctrl && info_q.ch_done_b) begin
            // channel 7 completes at once
            mem_wdata[dirb_pkg::START_BIT_POS] = 1'b0;
            if (dicr_master_enable && dicr2_enables[0]) begin
              dicr2_flags_next[0] = 1'b1;
            end
            dicr_master_flag_next = dicr_master_enable &&
                                    ((dicr_flags != '0) || (dicr2_flags_next != '0));
            if (dicr_master_flag_next) begin
              irq_status_next[3] = 1'b1;
            end
          end else if (info_q.ch_ctrl && wdata_q[dirb_pkg::START_BIT_POS]) begin
            fault = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      case (info_q.kind)
        dirb_pkg::KIND_ISTAT:     rd_word = irq_status;
        dirb_pkg::KIND_IMASK:     rd_word = irq_mask;
        dirb_pkg::KIND_ICTRL: begin
          rd_word           = {31'd0, irq_ctrl_bit};
          irq_ctrl_bit_next = 1'b0;
        end
        dirb_pkg::KIND_DICR:
          rd_word = {dicr_master_flag, dicr_flags, dicr_master_enable, dicr_enables,
                     dicr_low_ctrl};
        dirb_pkg::KIND_DPCR2:     rd_word = priority_word;
        dirb_pkg::KIND_DICR2:     rd_word = {1'b0, dicr2_flags, 1'b0, dicr2_enables,
                                             dicr2_tag_bits};
        dirb_pkg::KIND_DMACEN:    rd_word = dma_enable_word;
        dirb_pkg::KIND_DMACINTEN: rd_word = dma_int_enable_word;
        dirb_pkg::KIND_CHAN:      rd_word = mem_valid_q ? mem_q : '0;
        default:                  rd_word = '0;
      endcase
    end
  end

  // Sub-word reads shift the aligned word right
  always_comb begin
    if (info_q.is_write == dirb_pkg::CMD_WRITE) begin
      rd_result = '0;
    end else begin
      case (info_q.size)
        dirb_pkg::SIZE_BYTE: rd_result = rd_word >> {info_q.byte_lane, 3'b000};
        dirb_pkg::SIZE_HALF: rd_result = rd_word >> {info_q.byte_lane[1], 4'b0000};
        default:             rd_result = rd_word;
      endcase
    end
  end

  // Register state update
  always_ff @(posedge clk) begin
    if (rst) begin
      irq_status          <= '0;
      irq_mask            <= '0;
      irq_ctrl_bit        <= 1'b0;
      dicr_low_ctrl       <= '0;
      dicr_enables        <= '0;
      dicr_master_enable  <= 1'b0;
      dicr_flags          <= '0;
      dicr_master_flag    <= 1'b0;
      dicr2_tag_bits      <= '0;
      dicr2_enables       <= '0;
      dicr2_flags         <= '0;
      priority_word       <= '0;
      dma_enable_word     <= '0;
      dma_int_enable_word <= '0;
    end else if (commit) begin
      irq_status          <= irq_status_next;
      irq_mask            <= irq_mask_next;
      irq_ctrl_bit        <= irq_ctrl_bit_next;
      dicr_low_ctrl       <= dicr_low_ctrl_next;
      dicr_enables        <= dicr_enables_next;
      dicr_master_enable  <= dicr_master_enable_next;
      dicr_flags          <= dicr_flags_next;
      dicr_master_flag    <= dicr_master_flag_next;
      dicr2_tag_bits      <= dicr2_tag_bits_next;
      dicr2_enables       <= dicr2_enables_next;
      dicr2_flags         <= dicr2_flags_next;
      priority_word       <= priority_word_next;
      dma_enable_word     <= dma_enable_word_next;
      dma_int_enable_word <= dma_int_enable_word_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (commit) begin
      read_data_q   <= rd_result;
      decoded_q     <= hit;
      start_fault_q <= fault;
    end
  end

  assign m_tdata = {6'd0, start_fault_q, decoded_q, read_data_q};

  // Checks
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted item did not enter execute");

  a_fault_decoded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!start_fault_q || decoded_q))
    else $error("start fault on an unmapped access");

  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !decoded_q) |-> read_data_q == '0)
    else $error("unmapped access returned data");

  a_mflag_source: assert property (@(posedge clk) disable iff (rst)
    dicr_master_flag |-> ((dicr_flags != '0) || (dicr2_flags != '0)))
    else $error("master flag set with no channel flag");

endmodule

// ----- sim/tb_dma_interrupt_register_block.sv -----
// Self-checking testbench for the DMA/interrupt register block: directed table, then random accesses.
`timescale 1ns / 1ps

module tb_dma_interrupt_register_block;
  import dirb_pkg::*;

  localparam int CHANNELS         = 13;
  localparam int RANDOM_PER_PHASE = 500;
  localparam int NUM_DIRECTED     = 26;
  localparam logic [1:0]  SIZE_WORD_ALT = 2'd3;  // spare size code, behaves as a word
  localparam logic [31:0] CH_HI_END     = A_CH_HI + 32'((CHANNELS - 7) * 16);
  localparam logic [31:0] CH4_CTRL = A_CH_LO + 32'(16 * CH_DONE_A) + 32'(4 * CH_CTRL_SLOT);
  localparam logic [31:0] CH7_CTRL = A_CH_HI + 32'(16 * (CH_DONE_B - 7)) + 32'(4 * CH_CTRL_SLOT);

  // One bus access, packed as it travels on s_tdata
  typedef struct packed {
    logic [1:0]  size;
    logic [31:0] wdata;
    logic [31:0] addr;
    logic        cmd;
  } bus_access_t;

  // One reply, packed as it travels on m_tdata[33:0]
  typedef struct packed {
    logic        start_fault;
    logic        decoded;
    logic [31:0] read_data;
  } bus_reply_t;

  // Directed row; the literal reply is used only where lit is set
  typedef struct packed {
    logic        cmd;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic [1:0]  size;
    logic        lit;
    logic [31:0] want_data;
    logic        want_decoded;
    logic        want_fault;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    // reset values and address extremes
    '{CMD_READ,  A_ISTAT,          32'h0,         SIZE_WORD, 1'b1, 32'h0,        1'b1, 1'b0},
    '{CMD_READ,  32'h1F80_155C,    32'h0,         SIZE_WORD, 1'b1, 32'h0,        1'b1, 1'b0},
    '{CMD_READ,  32'h1F80_1000,    32'h0,         SIZE_WORD, 1'b1, 32'h0,        1'b0, 1'b0},
    '{CMD_WRITE, ADDR_IGNORE,      32'hFFFF_FFFF, SIZE_WORD, 1'b1, 32'h0,        1'b0, 1'b0},
    '{CMD_READ,  32'hFFFF_FFFF,    32'h0,         SIZE_BYTE, 1'b1, 32'h0,        1'b0, 1'b0},
    // mask via alias, spare size code and byte lane
    '{CMD_WRITE, A_IMASK,          32'hFFFF_FFFF, SIZE_WORD, 1'b1, 32'h0,        1'b1, 1'b0},
    '{CMD_READ,  32'hFF80_1074,    32'h0,     SIZE_WORD_ALT, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b0},
    '{CMD_READ,  32'h1F80_1077,    32'h0,         SIZE_BYTE, 1'b1, 32'h0000_00FF, 1'b1, 1'b0},
    // control bit clears on any read
    '{CMD_WRITE, A_ICTRL,          32'hFFFF_FFFF, SIZE_WORD, 1'b1, 32'h0,        1'b1, 1'b0},
    '{CMD_READ,  32'h1F80_107A,    32'h0,         SIZE_HALF, 1'b1, 32'h0,        1'b1, 1'b0},
    '{CMD_READ,  A_ICTRL,          32'h0,         SIZE_WORD, 1'b1, 32'h0,        1'b1, 1'b0},
    // named register off its exact address
    '{CMD_WRITE, 32'h1F80_1071,    32'h0,         SIZE_BYTE, 1'b1, 32'h0,        1'b0, 1'b0},
    // arm interrupts, then complete channels 4 and 7
    '{CMD_WRITE, A_DICR,           32'h00FF_ABCD, SIZE_WORD, 1'b0, 32'h0,        1'b0, 1'b0},
    '{CMD_WRITE, A_DICR2,          32'h0001_1234, SIZE_WORD, 1'b0, 32'h0,        1'b0, 1'b0},
    '{CMD_WRITE, CH4_CTRL + 32'd1, 32'h0100_0001, SIZE_BYTE, 1'b0, 32'h0,        1'b0, 1'b0},
    '{CMD_WRITE, CH7_CTRL,         32'hFFFF_FFFF, SIZE_WORD, 1'b0, 32'h0,        1'b0, 1'b0},
    '{CMD_READ,  A_DICR,           32'h0,         SIZE_WORD, 1'b0, 32'h0,        1'b0, 1'b0},
    '{CMD_READ,  CH4_CTRL + 32'd2, 32'h0,         SIZE_HALF, 1'b0, 32'h0,        1'b0, 1'b0},
    '{CMD_READ,  A_ISTAT,          32'h0,         SIZE_WORD, 1'b0, 32'h0,        1'b0, 1'b0},
    // unsupported channels started
    '{CMD_WRITE, A_CH_LO + 32'h8,  32'h0100_0000, SIZE_WORD, 1'b1, 32'h0,        1'b1, 1'b1},
    '{CMD_WRITE, 32'h1F80_1558,    32'hFFFF_FFFF, SIZE_WORD, 1'b1, 32'h0,        1'b1, 1'b1},
    // flag clear by ones, DICR2 byte lane
    '{CMD_WRITE, A_DICR,           32'h7F00_0000, SIZE_WORD, 1'b0, 32'h0,        1'b0, 1'b0},
    '{CMD_READ,  32'h1F80_1577,    32'h0,         SIZE_BYTE, 1'b0, 32'h0,        1'b0, 1'b0},
    // priority / enable words, unshifted-mask byte read
    '{CMD_WRITE, A_DMACINTEN,      32'hFFFF_FFFF, SIZE_WORD, 1'b1, 32'h0,        1'b1, 1'b0},
    '{CMD_READ,  A_DPCR2,          32'h0,         SIZE_WORD, 1'b1, 32'h0,        1'b1, 1'b0},
    '{CMD_READ,  32'h1F80_157D,    32'h0,         SIZE_BYTE, 1'b1, 32'h00FF_FFFF, 1'b1, 1'b0}
  };

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int error_count = 0;
  bus_reply_t pending_replies [$];

  // Shadow copy of the register state
  logic [31:0] rf_istat       = '0;
  logic [31:0] rf_imask       = '0;
  logic        rf_ictrl       = 1'b0;
  logic [15:0] rf_dicr_ctrl   = '0;
  logic [6:0]  rf_dicr_en     = '0;
  logic        rf_dicr_men    = 1'b0;
  logic [6:0]  rf_dicr_flags  = '0;
  logic        rf_dicr_mflag  = 1'b0;
  logic [15:0] rf_dicr2_tag   = '0;
  logic [6:0]  rf_dicr2_en    = '0;
  logic [6:0]  rf_dicr2_flags = '0;
  logic [31:0] rf_dpcr2       = '0;
  logic [31:0] rf_dmacen      = '0;
  logic [31:0] rf_dmacinten   = '0;
  logic [31:0] rf_chan [CHANNELS*4] = '{default: '0};

  dma_interrupt_register_block #(.CHANNEL_COUNT(CHANNELS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Channel word index of a masked address, or -1 outside the channel windows
  function automatic int chan_word(logic [31:0] a);
    int ch;
    if (a >= A_CH_LO && a < A_CH_LO_END) ch = int'(a[7:4]) - 8;
    else if (a >= A_CH_HI && a < CH_HI_END) ch = int'(a[7:4]) + 7;
    else return -1;
    if (ch < 0 || ch >= CHANNELS) return -1;
    return ch * 4 + int'(a[3:2]);
  endfunction

  // Expected reply of one access; updates the shadow state
  function automatic bus_reply_t predict_reply(bus_access_t acc);
    bus_reply_t reply;
    logic [31:0] a;
    logic [31:0] ra;
    logic [31:0] word;
    logic [1:0]  lane;
    int idx;
    int ch;
    reply = '0;
    word  = '0;
    if (acc.addr >= ADDR_IGNORE) return reply;
    a    = {3'b000, acc.addr[28:0]};
    lane = a[1:0];
    reply.decoded = 1'b1;
    if (acc.cmd == CMD_WRITE) begin
      case (a)
        A_ISTAT:     rf_istat = rf_istat & acc.wdata;
        A_IMASK:     rf_imask = acc.wdata;
        A_ICTRL:     rf_ictrl = acc.wdata[0];
        A_DICR: begin
          rf_dicr_ctrl  = acc.wdata[15:0];
          rf_dicr_en    = acc.wdata[22:16];
          rf_dicr_men   = acc.wdata[23];
          rf_dicr_flags = rf_dicr_flags & ~acc.wdata[30:24];
          rf_dicr_mflag = (|rf_dicr_flags) || (|rf_dicr2_flags);
        end
        A_DICR2: begin
          rf_dicr2_tag   = acc.wdata[15:0];
          rf_dicr2_en    = acc.wdata[22:16];
          rf_dicr2_flags = rf_dicr2_flags & ~acc.wdata[30:24];
          rf_dicr_mflag  = (|rf_dicr_flags) || (|rf_dicr2_flags);
        end
        A_DPCR2:     rf_dpcr2 = acc.wdata;
        A_DMACEN:    rf_dmacen = acc.wdata;
        A_DMACINTEN: rf_dmacinten = acc.wdata;
        default: begin
          idx = chan_word(a);
          if (idx < 0) begin
            reply.decoded = 1'b0;
          end else begin
            rf_chan[idx] = acc.wdata;
            ch = idx / 4;
            if (idx % 4 == int'(CH_CTRL_SLOT)) begin
              if (ch == int'(CH_DONE_A) || ch == int'(CH_DONE_B)) begin
                // instant completion: drop start, raise flag, refresh master flag
                rf_chan[idx][START_BIT_POS] = 1'b0;
                if (ch == int'(CH_DONE_A) && rf_dicr_men && rf_dicr_en[4])
                  rf_dicr_flags[4] = 1'b1;
                if (ch == int'(CH_DONE_B) && rf_dicr_men && rf_dicr2_en[0])
                  rf_dicr2_flags[0] = 1'b1;
                rf_dicr_mflag = rf_dicr_men && ((|rf_dicr_flags) || (|rf_dicr2_flags));
                if (rf_dicr_mflag) rf_istat[3] = 1'b1;
              end else if (acc.wdata[START_BIT_POS]) begin
                reply.start_fault = 1'b1;
              end
            end
          end
        end
      endcase
    end else begin
      // sub-word reads fetch the aligned word
      ra = (acc.size == SIZE_BYTE || acc.size == SIZE_HALF) ? {a[31:2], 2'b00} : a;
      case (ra)
        A_ISTAT:     word = rf_istat;
        A_IMASK:     word = rf_imask;
        A_ICTRL: begin
          word     = {31'b0, rf_ictrl};
          rf_ictrl = 1'b0;
        end
        A_DICR:      word = {rf_dicr_mflag, rf_dicr_flags, rf_dicr_men, rf_dicr_en, rf_dicr_ctrl};
        A_DPCR2:     word = rf_dpcr2;
        A_DICR2:     word = {1'b0, rf_dicr2_flags, 1'b0, rf_dicr2_en, rf_dicr2_tag};
        A_DMACEN:    word = rf_dmacen;
        A_DMACINTEN: word = rf_dmacinten;
        default: begin
          idx = chan_word(ra);
          if (idx < 0) reply.decoded = 1'b0;
          else word = rf_chan[idx];
        end
      endcase
      case (acc.size)
        SIZE_BYTE: reply.read_data = word >> (8 * lane);
        SIZE_HALF: reply.read_data = word >> (16 * lane[1]);
        default:   reply.read_data = word;
      endcase
    end
    return reply;
  endfunction

  // Random access: mostly register hits, some completions, some noise
  function automatic bus_access_t random_access();
    bus_access_t acc;
    int sel;
    int ch;
    sel       = $urandom_range(0, 99);
    acc.cmd   = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
    acc.size  = 2'($urandom_range(0, 3));
    acc.wdata = $urandom;
    if (sel < 8) begin
      acc.addr = $urandom;
    end else if (sel < 12) begin
      acc.addr = ADDR_IGNORE | 32'($urandom_range(0, 32'h1FFFF));
    end else if (sel < 45) begin
      case ($urandom_range(0, 7))
        0: acc.addr = A_ISTAT;
        1: acc.addr = A_IMASK;
        2: acc.addr = A_ICTRL;
        3: acc.addr = A_DICR;
        4: acc.addr = A_DPCR2;
        5: acc.addr = A_DICR2;
        6: acc.addr = A_DMACEN;
        default: acc.addr = A_DMACINTEN;
      endcase
      if ($urandom_range(0, 3) == 0) acc.addr[1:0] = 2'($urandom_range(0, 3));
    end else if (sel < 85) begin
      ch = $urandom_range(0, CHANNELS - 1);
      acc.addr = (ch < 7) ? A_CH_LO + 32'(16 * ch) : A_CH_HI + 32'(16 * (ch - 7));
      acc.addr = acc.addr + 32'($urandom_range(0, 15));
    end else begin
      // completion traffic: start ch4/ch7 or arm the interrupt enables
      acc.cmd = CMD_WRITE;
      case ($urandom_range(0, 2))
        0: acc.addr = CH4_CTRL;
        1: acc.addr = CH7_CTRL;
        default: begin
          acc.addr = $urandom_range(0, 1) ? A_DICR : A_DICR2;
          if ($urandom_range(0, 3) != 0) acc.wdata[23:16] = 8'hFF;
          if ($urandom_range(0, 1)) acc.wdata[30:24] = 7'h00;
        end
      endcase
    end
    // upper-bit aliases of mapped addresses
    if (sel >= 12 && $urandom_range(0, 4) == 0) acc.addr[31:29] = 3'($urandom_range(0, 7));
    return acc;
  endfunction

  // Drive one item, wait for acceptance, record its expected reply
  task automatic issue_access(input bus_access_t acc, input logic use_lit,
                              input bus_reply_t lit_reply);
    bus_reply_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, acc.size, acc.wdata, acc.addr, acc.cmd};
    do @(posedge clk); while (!s_tready);
    predicted = predict_reply(acc);
    pending_replies.push_back(use_lit ? lit_reply : predicted);
  endtask

  // Hold off the sender until every reply is back
  task automatic drain_replies();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Reply checker
  always @(posedge clk) begin
    bus_reply_t got;
    bus_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[33:0];
      if (pending_replies.size() == 0) begin
        $error("reply with no access outstanding: %h", m_tdata);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (got.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, got.read_data);
          error_count++;
        end
        if (got.decoded !== want.decoded) begin
          $error("decoded: expected %b, got %b", want.decoded, got.decoded);
          error_count++;
        end
        if (got.start_fault !== want.start_fault) begin
          $error("start_fault: expected %b, got %b", want.start_fault, got.start_fault);
          error_count++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    bus_access_t acc;
    bus_reply_t  lit;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 27;
    rx_idle_pct = 60;
    foreach (DIRECTED_ROWS[i]) begin
      acc.cmd   = DIRECTED_ROWS[i].cmd;
      acc.addr  = DIRECTED_ROWS[i].addr;
      acc.wdata = DIRECTED_ROWS[i].wdata;
      acc.size  = DIRECTED_ROWS[i].size;
      lit = {DIRECTED_ROWS[i].want_fault, DIRECTED_ROWS[i].want_decoded,
             DIRECTED_ROWS[i].want_data};
      issue_access(acc, DIRECTED_ROWS[i].lit, lit);
    end
    drain_replies();

    // receiver-heavy idling, then sender-heavy, then back to back
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 60 : 0;
      rx_idle_pct = (phase == 0) ? 60 : (phase == 1) ? 27 : 0;
      repeat (RANDOM_PER_PHASE) issue_access(random_access(), 1'b0, '0);
      drain_replies();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
